@@ hw/rtl/rls_pkg.sv @@
// Shared types, codes and default constants for the rotating LED segment driver.
package rls_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int TICK_STEP_DEF = 1024;

    // Segment numbers stay below the largest LED count of 64.
    localparam int SEG_W = 6;

    // Depth of the command queue between the front and back parts.
    localparam int CMD_DEPTH = 4;

    // Request codes on req_type.
    localparam logic [1:0] REQ_CAPTURE = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_WRITE   = 2'd2;

    // Bus register that addresses the brightness table.
    localparam logic [7:0] BUS_REG_TABLE = 8'd2;

    // Result kinds on result_kind.
    localparam logic RES_DRIVE = 1'b0;
    localparam logic RES_ACK   = 1'b1;

    // Brightness byte held by table entry 0 after reset.
    localparam logic [7:0] TABLE_ENTRY0_RESET = 8'd250;

    // Gamma curve constants.
    localparam logic [7:0] GAMMA_KNEE  = 8'd252;
    localparam logic [9:0] GAMMA_MAX   = 10'd1010;
    localparam logic [9:0] PWM_TOP     = 10'd1023;

    // One command handed from the front part to the back part.
    typedef struct packed {
        logic        is_write;
        logic        wr_ok;
        logic [4:0]  wr_index;
        logic [7:0]  wr_value;
        logic [1:0]  color;
        logic [31:0] elapsed;
        logic [31:0] length;
    } cmd_t;

endpackage

@@ hw/rtl/rls_front.sv @@
// Front part: accepts request beats, keeps the rotation timing state, issues commands.
module rls_front #(
    parameter int LED_COUNT = rls_pkg::LED_COUNT_DEF,
    parameter int TICK_STEP = rls_pkg::TICK_STEP_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          full,
    input  logic [1:0]    req_type,
    input  logic [9:0]    timer_count,
    input  logic [7:0]    bus_register,
    input  logic [4:0]    write_index,
    input  logic [7:0]    write_value,
    output logic          cmd_push,
    output rls_pkg::cmd_t cmd
);

    localparam logic [7:0]  TableLen = 8'(3 * LED_COUNT);
    localparam logic [31:0] TickStep = 32'(TICK_STEP);

    logic [31:0] time_base_reg,       time_base_next;
    logic [31:0] phase_start_reg,     phase_start_next;
    logic [31:0] previous_phase_reg,  previous_phase_next;
    logic [31:0] rotation_start_reg,  rotation_start_next;
    logic [31:0] rotation_length_reg, rotation_length_next;
    logic [1:0]  color_reg,           color_next;

    logic        accept;
    logic [31:0] now;
    logic [31:0] phase;
    logic [31:0] tick_base;

    assign accept    = push && !full;
    assign now       = time_base_reg + {22'd0, timer_count};
    assign phase     = now - phase_start_reg;
    assign tick_base = time_base_reg + TickStep;

    always_comb
    begin
        time_base_next       = time_base_reg;
        phase_start_next     = phase_start_reg;
        previous_phase_next  = previous_phase_reg;
        rotation_start_next  = rotation_start_reg;
        rotation_length_next = rotation_length_reg;
        color_next           = color_reg;
        cmd_push             = 1'b0;
        cmd                  = '0;
        if (accept)
        begin
            unique case (req_type)
                rls_pkg::REQ_CAPTURE:
                begin
                    phase_start_next    = now;
                    previous_phase_next = phase;
                    // A phase longer than the one before marks a new rotation.
                    if (phase > previous_phase_reg)
                    begin
                        rotation_length_next = now - rotation_start_reg;
                        rotation_start_next  = now;
                    end
                end
                rls_pkg::REQ_TICK:
                begin
                    time_base_next = tick_base;
                    color_next     = (color_reg >= 2'd2) ? 2'd0 : color_reg + 2'd1;
                    cmd_push       = 1'b1;
                    cmd.is_write   = 1'b0;
                    cmd.color      = color_next;
                    cmd.elapsed    = tick_base + {22'd0, timer_count} - rotation_start_reg;
                    cmd.length     = rotation_length_reg;
                end
                rls_pkg::REQ_WRITE:
                begin
                    cmd_push     = 1'b1;
                    cmd.is_write = 1'b1;
                    cmd.wr_ok    = (bus_register == rls_pkg::BUS_REG_TABLE)
                                   && ({3'd0, write_index} < TableLen);
                    cmd.wr_index = write_index;
                    cmd.wr_value = write_value;
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_base_reg       <= '0;
            phase_start_reg     <= '0;
            previous_phase_reg  <= '0;
            rotation_start_reg  <= '0;
            rotation_length_reg <= '0;
            color_reg           <= '0;
        end
        else
        begin
            time_base_reg       <= time_base_next;
            phase_start_reg     <= phase_start_next;
            previous_phase_reg  <= previous_phase_next;
            rotation_start_reg  <= rotation_start_next;
            rotation_length_reg <= rotation_length_next;
            color_reg           <= color_next;
        end
    end

    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        color_reg != 2'd3)
        else $error("color channel left its range");

endmodule

@@ hw/rtl/rls_cmd_fifo.sv @@
// Short command queue between the front and back parts.
module rls_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rls_pkg::cmd_t push_data,
    input  logic          pop,
    output rls_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);

    localparam int PtrW = $clog2(rls_pkg::CMD_DEPTH);
    localparam int CntW = $clog2(rls_pkg::CMD_DEPTH + 1);
    localparam logic [CntW-1:0] Depth = CntW'(rls_pkg::CMD_DEPTH);
    localparam logic [PtrW-1:0] LastSlot = PtrW'(rls_pkg::CMD_DEPTH - 1);

    rls_pkg::cmd_t   mem [rls_pkg::CMD_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full     = (count_reg == Depth);
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastSlot) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastSlot) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("command popped from an empty queue");

endmodule

@@ hw/rtl/rls_back.sv @@
// Back part: segment division, brightness table, gamma curve and the result register.
module rls_back #(
    parameter int LED_COUNT = rls_pkg::LED_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  rls_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          out_valid,
    output logic          result_kind,
    output logic [1:0]    color_channel,
    output logic [9:0]    pwm_compare,
    output logic          write_accepted
);

    // Write indexes are 5 bits wide, so only the first 32 bytes can ever change.
    localparam int TableLen = 3 * LED_COUNT;
    localparam int TblDepth = (TableLen < 32) ? TableLen : 32;
    localparam int TiW      = $clog2(TblDepth);
    localparam logic [7:0]  TblDepthW = 8'(TblDepth);
    localparam logic [7:0]  LedCountW = 8'(LED_COUNT);
    localparam logic [31:0] LedMul    = 32'(LED_COUNT);
    // Rounded-up reciprocal of the LED count in 16 fraction bits; exact for 8-bit values.
    localparam logic [16:0] ModRecip  = 17'((65536 + LED_COUNT - 1) / LED_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_MUL,
        S_DIV,
        S_MOD,
        S_READ,
        S_GAMMA,
        S_EMIT
    } state_t;

    state_t                   state_reg;
    rls_pkg::cmd_t            cmd_reg;
    logic [31:0]              dq_reg;
    logic [31:0]              rem_reg;
    logic [4:0]               cnt_reg;
    logic [rls_pkg::SEG_W-1:0] seg_reg;
    logic [7:0]               byte_reg;
    logic [9:0]               res_compare_reg;
    logic                     res_kind_reg;
    logic                     res_ok_reg;
    logic                     out_valid_reg;
    logic                     result_kind_reg;
    logic [1:0]               color_channel_reg;
    logic [9:0]               pwm_compare_reg;
    logic                     write_accepted_reg;
    logic [7:0]               table_mem [TblDepth];

    logic [32:0]              div_trial;
    logic                     div_fits;
    logic [23:0]              mod_prod;
    logic [7:0]               mod_quot;
    logic [7:0]               mod_back;
    logic [7:0]               seg_mod;
    logic [7:0]               pos;
    logic [15:0]              square;
    logic [9:0]               gamma;
    logic                     slot_free;

    assign cmd_pop   = (state_reg == S_IDLE) && !cmd_empty;
    assign slot_free = !out_valid_reg || pop;

    assign div_trial = {rem_reg, dq_reg[31]};
    assign div_fits  = (div_trial >= {1'b0, cmd_reg.length});

    // Remainder of the low quotient byte by the LED count through a reciprocal multiply.
    assign mod_prod  = {16'd0, dq_reg[7:0]} * {7'd0, ModRecip};
    assign mod_quot  = mod_prod[23:16];
    assign mod_back  = mod_quot * LedCountW;
    assign seg_mod   = dq_reg[7:0] - mod_back;

    assign pos       = ({2'd0, seg_reg} * 8'd3) + {6'd0, cmd_reg.color};
    assign square    = {8'd0, byte_reg} * {8'd0, byte_reg};
    assign gamma     = (byte_reg > rls_pkg::GAMMA_KNEE) ? rls_pkg::GAMMA_MAX : square[15:6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TblDepth; i++)
            begin
                table_mem[i] <= (i == 0) ? rls_pkg::TABLE_ENTRY0_RESET : 8'd0;
            end
        end
        else if (state_reg == S_WRITE && cmd_reg.wr_ok)
        begin
            table_mem[cmd_reg.wr_index[TiW-1:0]] <= cmd_reg.wr_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            out_valid_reg      <= 1'b0;
            cnt_reg            <= '0;
            cmd_reg            <= '0;
            dq_reg             <= '0;
            rem_reg            <= '0;
            seg_reg            <= '0;
            byte_reg           <= '0;
            res_compare_reg    <= '0;
            res_kind_reg       <= rls_pkg::RES_DRIVE;
            res_ok_reg         <= 1'b0;
            result_kind_reg    <= rls_pkg::RES_DRIVE;
            color_channel_reg  <= '0;
            pwm_compare_reg    <= '0;
            write_accepted_reg <= 1'b0;
        end
        else
        begin
            // In S_EMIT the output register is refilled instead, so it is not cleared here.
            if (out_valid_reg && pop && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= cmd.is_write ? S_WRITE : S_MUL;
                    end
                end
                S_WRITE:
                begin
                    res_kind_reg    <= rls_pkg::RES_ACK;
                    res_ok_reg      <= cmd_reg.wr_ok;
                    res_compare_reg <= '0;
                    state_reg       <= S_EMIT;
                end
                S_MUL:
                begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (cmd_reg.length == '0)
                    begin
                        // No rotation measured yet: segment 0.
                        dq_reg    <= '0;
                        state_reg <= S_MOD;
                    end
                    else
                    begin
                        dq_reg    <= 32'(cmd_reg.elapsed * LedMul);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= div_fits ? 32'(div_trial - {1'b0, cmd_reg.length})
                                        : div_trial[31:0];
                    dq_reg  <= {dq_reg[30:0], div_fits};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    seg_reg   <= seg_mod[rls_pkg::SEG_W-1:0];
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    byte_reg  <= (pos < TblDepthW) ? table_mem[pos[TiW-1:0]] : 8'd0;
                    state_reg <= S_GAMMA;
                end
                S_GAMMA:
                begin
                    res_kind_reg    <= rls_pkg::RES_DRIVE;
                    res_ok_reg      <= 1'b0;
                    res_compare_reg <= rls_pkg::PWM_TOP - gamma;
                    state_reg       <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        result_kind_reg    <= res_kind_reg;
                        color_channel_reg  <= (res_kind_reg == rls_pkg::RES_ACK)
                                              ? 2'd0 : cmd_reg.color;
                        pwm_compare_reg    <= res_compare_reg;
                        write_accepted_reg <= res_ok_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = result_kind_reg;
    assign color_channel  = color_channel_reg;
    assign pwm_compare    = pwm_compare_reg;
    assign write_accepted = write_accepted_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cmd_reg.length != '0)
        else $error("division started with a zero rotation length");

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> {2'd0, seg_reg} < LedCountW)
        else $error("segment number outside the ring");

    a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && slot_free) |=> out_valid_reg)
        else $error("finished result not placed in the output register");

endmodule

@@ hw/rtl/rotating_led_segment_driver.sv @@
// Top level of the rotating LED segment driver: front part, command queue, back part.
//
// Usage: request beats enter through push/full and are taken at an edge with push high
// and full low. A capture beat updates the rotation timing at once and gives no result.
// A tick beat advances time, steps the color channel and yields one drive result with
// the PWM compare value for the segment that the ring currently faces. A table write
// beat yields one acknowledge result; write_accepted tells whether the byte was stored.
// Request type 3 is dropped without a result.
// Results leave through empty/pop; the oldest result stays on the ports while empty is
// low and is taken at an edge with pop high and empty low.
// Path: a tick passes S_MUL, the 32-step restoring divider that finds the segment (skipped
// while no rotation length is known), S_MOD, S_READ, S_GAMMA and S_EMIT; a table write
// passes S_WRITE and S_EMIT. The back part handles one command at a time and takes no
// new command before the last result is placed in the output register; captures need
// no back work.
// A four-entry command queue decouples the two parts, so request beats keep being
// taken while a result waits. When the receiver stalls, the waiting result holds, the
// back part stops before delivery, and full rises once the queue fills up.
// Reset clears all timing state, sets the color channel to 0 and loads the brightness
// table with 250 in entry 0 and 0 elsewhere; the block is ready the cycle after reset.
module rotating_led_segment_driver #(
    parameter int LED_COUNT = rls_pkg::LED_COUNT_DEF,
    parameter int TICK_STEP = rls_pkg::TICK_STEP_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] req_type,
    input  logic [9:0] timer_count,
    input  logic [7:0] bus_register,
    input  logic [4:0] write_index,
    input  logic [7:0] write_value,
    output logic       empty,
    input  logic       pop,
    output logic       result_kind,
    output logic [1:0] color_channel,
    output logic [9:0] pwm_compare,
    output logic       write_accepted
);

    logic          cmd_push;
    rls_pkg::cmd_t cmd_in;
    rls_pkg::cmd_t cmd_out;
    logic          cmd_pop;
    logic          cmd_empty;
    logic          out_valid;

    rls_front #(
        .LED_COUNT (LED_COUNT),
        .TICK_STEP (TICK_STEP)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .timer_count  (timer_count),
        .bus_register (bus_register),
        .write_index  (write_index),
        .write_value  (write_value),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    // Queue full also holds off captures, which keeps request order simple.
    rls_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .full      (full),
        .empty     (cmd_empty)
    );

    rls_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_empty      (cmd_empty),
        .cmd            (cmd_out),
        .cmd_pop        (cmd_pop),
        .pop            (pop),
        .out_valid      (out_valid),
        .result_kind    (result_kind),
        .color_channel  (color_channel),
        .pwm_compare    (pwm_compare),
        .write_accepted (write_accepted)
    );

    assign empty = !out_valid;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the rotating LED segment driver: predictor, stimulus and checks.
`timescale 1ns / 1ps

module tb_top;

    // Request type 3 has no meaning to the block; it must be dropped without a result.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CLK_HALF      = 4;
    localparam int RANDOM_ITEMS  = 1700;
    // Long receiver hold-off, long enough for the command queue to fill and raise full.
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 150;
    // Quiet time at the end, longer than a tick takes in the back part, so that a late or
    // extra result is still caught.
    localparam int DRAIN_CYCLES  = 60;
    // The limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT   = 500000;

    // Predictor and store of awaited results for the LED ring driver.
    class segment_scoreboard;
        localparam bit [31:0] LEDS      = rls_pkg::LED_COUNT_DEF;
        localparam int        CHANNELS  = 3;
        localparam int        TABLE_LEN = CHANNELS * rls_pkg::LED_COUNT_DEF;
        localparam int        GAMMA_SHIFT = 6;

        typedef struct packed {
            logic       kind;
            logic [1:0] channel;
            logic [9:0] compare;
            logic       accepted;
        } drive_beat_t;

        bit [31:0] time_base;
        bit [31:0] phase_start;
        bit [31:0] previous_phase;
        bit [31:0] rotation_start;
        bit [31:0] rotation_length;
        bit [1:0]  color_index;
        bit [7:0]  brightness [TABLE_LEN];
        drive_beat_t awaited [$];

        int unsigned mismatches;
        int unsigned checked;
        int unsigned ticks;
        int unsigned captures;
        int unsigned rotations;
        int unsigned writes;
        int unsigned stored;
        int unsigned ignored;
        bit [rls_pkg::LED_COUNT_DEF-1:0] segments_seen;

        function new();
            foreach (brightness[i])
                brightness[i] = 8'd0;
            brightness[0] = rls_pkg::TABLE_ENTRY0_RESET;
        endfunction

        function bit [9:0] gamma_of(bit [7:0] level);
            bit [15:0] square;
            if (level > rls_pkg::GAMMA_KNEE)
                return rls_pkg::GAMMA_MAX;
            square = {8'd0, level} * {8'd0, level};
            return 10'(square >> GAMMA_SHIFT);
        endfunction

        // Angular segment the ring faces at this timer count; zero until a rotation is known.
        function bit [31:0] segment_at(bit [9:0] count);
            bit [31:0] elapsed;
            bit [31:0] scaled;
            bit [31:0] quotient;
            elapsed = time_base + {22'd0, count} - rotation_start;
            if (rotation_length == 32'd0)
                return 32'd0;
            scaled = elapsed * LEDS;
            quotient = scaled / rotation_length;
            return {24'd0, quotient[7:0]} % LEDS;
        endfunction

        function void note_request(bit [1:0] kind, bit [9:0] count, bit [7:0] reg_addr,
                                   bit [4:0] index, bit [7:0] value);
            bit [31:0] now;
            bit [31:0] phase;
            bit [31:0] seg;
            bit [31:0] pos;
            drive_beat_t beat;
            beat = '0;
            case (kind)
                rls_pkg::REQ_CAPTURE:
                begin
                    captures++;
                    now = time_base + {22'd0, count};
                    phase = now - phase_start;
                    phase_start = now;
                    if (phase > previous_phase)
                    begin
                        rotation_length = now - rotation_start;
                        rotation_start = now;
                        rotations++;
                    end
                    previous_phase = phase;
                end
                rls_pkg::REQ_TICK:
                begin
                    ticks++;
                    time_base += 32'(rls_pkg::TICK_STEP_DEF);
                    color_index = (color_index >= 2'(CHANNELS - 1)) ? 2'd0 : color_index + 2'd1;
                    seg = segment_at(count);
                    if (rotation_length != 32'd0)
                        segments_seen[seg] = 1'b1;
                    pos = seg * CHANNELS + color_index;
                    beat.kind = rls_pkg::RES_DRIVE;
                    beat.channel = color_index;
                    beat.compare = rls_pkg::PWM_TOP -
                        ((pos < TABLE_LEN) ? gamma_of(brightness[pos]) : 10'd0);
                    awaited.push_back(beat);
                end
                rls_pkg::REQ_WRITE:
                begin
                    writes++;
                    beat.kind = rls_pkg::RES_ACK;
                    if (reg_addr == rls_pkg::BUS_REG_TABLE && index < TABLE_LEN)
                    begin
                        brightness[index] = value;
                        beat.accepted = 1'b1;
                        stored++;
                    end
                    awaited.push_back(beat);
                end
                default:
                    ignored++;
            endcase
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("result beat %0d: %s: got %0d, expected %0d", checked, what, got, want);
            mismatches++;
        endtask

        task check_result(logic kind, logic [1:0] channel, logic [9:0] compare, logic accepted);
            drive_beat_t want;
            checked++;
            if (awaited.size() == 0)
            begin
                report_mismatch("result with nothing outstanding, kind", 32'(kind), 32'd0);
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind)
                report_mismatch("result_kind", 32'(kind), 32'(want.kind));
            if (channel !== want.channel)
                report_mismatch("color_channel", 32'(channel), 32'(want.channel));
            if (compare !== want.compare)
                report_mismatch("pwm_compare", 32'(compare), 32'(want.compare));
            if (accepted !== want.accepted)
                report_mismatch("write_accepted", 32'(accepted), 32'(want.accepted));
        endtask

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] req_type = rls_pkg::REQ_CAPTURE;
    logic [9:0] timer_count = 10'd0;
    logic [7:0] bus_register = 8'd0;
    logic [4:0] write_index = 5'd0;
    logic [7:0] write_value = 8'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic       result_kind;
    logic [1:0] color_channel;
    logic [9:0] pwm_compare;
    logic       write_accepted;

    segment_scoreboard sb = new();

    int unsigned items_sent = 0;
    int unsigned full_stall_cycles = 0;
    int unsigned cycle_count = 0;
    bit sender_eager = 1'b0;
    bit receiver_eager = 1'b0;
    bit hold_done = 1'b0;

    rotating_led_segment_driver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .timer_count    (timer_count),
        .bus_register   (bus_register),
        .write_index    (write_index),
        .write_value    (write_value),
        .empty          (empty),
        .pop            (pop),
        .result_kind    (result_kind),
        .color_channel  (color_channel),
        .pwm_compare    (pwm_compare),
        .write_accepted (write_accepted)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog: a hung handshake must not leave the run spinning forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.outstanding());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one request beat. Every call is entered right after a rising edge. The idle
    // gap comes first with push low; with no gap, push stays high from the previous beat
    // so it never gets two assignments in one step. The beat is taken at the first edge
    // where full was low, and only then is the predictor told about it.
    task send_beat(bit [1:0] kind, bit [9:0] count, bit [7:0] reg_addr,
                   bit [4:0] index, bit [7:0] value);
        int idle;
        idle = sender_eager ? 0 : int'($urandom_range(0, 5));
        if (idle > 0)
        begin
            push <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        push         <= 1'b1;
        req_type     <= kind;
        timer_count  <= count;
        bus_register <= reg_addr;
        write_index  <= index;
        write_value  <= value;
        @(posedge clk);
        while (full)
        begin
            full_stall_cycles++;
            @(posedge clk);
        end
        sb.note_request(kind, count, reg_addr, index, value);
        if (kind != REQ_UNUSED)
            items_sent++;
    endtask

    task send_tick(bit [9:0] count);
        send_beat(rls_pkg::REQ_TICK, count, 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
    endtask

    task send_capture(bit [9:0] count);
        send_beat(rls_pkg::REQ_CAPTURE, count, 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
    endtask

    task send_write(bit [7:0] reg_addr, bit [4:0] index, bit [7:0] value);
        send_beat(rls_pkg::REQ_WRITE, 10'($urandom_range(0, 1023)), reg_addr, index, value);
    endtask

    // A run of PWM periods. Now and then the host rewrites a table byte in between,
    // mostly a valid one, sometimes to a wrong register or past the end of the table.
    task tick_run(int periods);
        for (int i = 0; i < periods; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_write(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                               8'($urandom_range(0, 255)));
                else
                    send_write(rls_pkg::BUS_REG_TABLE, 5'($urandom_range(0, 23)),
                               8'($urandom_range(0, 255)));
            end
            send_tick(10'($urandom_range(0, 1023)));
        end
    endtask

    // A spinning ring seen by the sensor: each turn has a short gap and a long gap between
    // edges, so the edge after the long gap marks a new rotation. Ticks fall throughout,
    // which walks the segment across the whole ring.
    task rotation_episode();
        int turns;
        int short_gap;
        int long_gap;
        sender_eager = ($urandom_range(0, 3) == 0);
        turns = int'($urandom_range(2, 5));
        short_gap = int'($urandom_range(0, 2));
        long_gap = short_gap + int'($urandom_range(1, 6));
        for (int t = 0; t < turns; t++)
        begin
            tick_run(short_gap);
            send_capture(10'($urandom_range(0, 1023)));
            tick_run(long_gap);
            send_capture(10'($urandom_range(0, 1023)));
        end
    endtask

    // Unstructured traffic: any request type with any field values.
    task noise_episode();
        sender_eager = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(5, 15))
            send_beat(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                      8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                      8'($urandom_range(0, 255)));
    endtask

    // Result side. The oldest result is compared at the edge where it is popped. Once,
    // after a fair number of results, pop is held low for a long stretch while the sender
    // keeps going, so the command queue fills and full must hold off the input.
    initial
    begin
        int idle;
        int unsigned taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            idle = receiver_eager ? 0 : int'($urandom_range(0, 5));
            if (!hold_done && sb.checked >= HOLD_AFTER)
            begin
                idle = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (idle > 0)
            begin
                pop <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            sb.check_result(result_kind, color_channel, pwm_compare, write_accepted);
            taken++;
            if (taken % 64 == 0)
                receiver_eager = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        int unsigned random_start;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first three ticks run before any rotation is known, so the
        // segment is forced to 0; the third lands on channel 0 and reads entry 0 as reset.
        sender_eager = 1'b1;
        send_tick(10'd0);
        send_tick(10'd1023);
        send_tick(10'd512);
        // Gamma corners: saturated byte, just above the knee, the knee itself, and zero.
        send_write(rls_pkg::BUS_REG_TABLE, 5'd0, 8'd255);
        send_write(rls_pkg::BUS_REG_TABLE, 5'd23, 8'd253);
        send_write(rls_pkg::BUS_REG_TABLE, 5'd1, 8'd252);
        send_write(rls_pkg::BUS_REG_TABLE, 5'd2, 8'd0);
        // Writes that must be refused: wrong registers and indexes past the table.
        send_write(8'd0, 5'd5, 8'd77);
        send_write(8'd255, 5'd4, 8'd1);
        send_write(rls_pkg::BUS_REG_TABLE, 5'd24, 8'd9);
        send_write(rls_pkg::BUS_REG_TABLE, 5'd31, 8'd200);
        // An unknown request type is dropped with no result and no state change.
        send_beat(REQ_UNUSED, 10'd1023, rls_pkg::BUS_REG_TABLE, 5'd0, 8'd255);
        // First edges: these start rotations and give the divider a real length.
        send_capture(10'd0);
        send_tick(10'd1023);
        send_capture(10'd1023);
        send_tick(10'd0);
        send_tick(10'd300);
        send_capture(10'd0);
        send_tick(10'd700);
        send_tick(10'd1023);

        // Random part: mostly well-formed rotations, with some noise mixed in.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
                rotation_episode();
            else
                noise_episode();
        end
        push <= 1'b0;

        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.outstanding() > 0)
            sb.report_mismatch("results never delivered", 32'(sb.outstanding()), 32'd0);

        $display("Covered %0d ticks, %0d rotation starts, segments %b, %0d captures,",
                 sb.ticks, sb.rotations, sb.segments_seen, sb.captures);
        $display("%0d writes (%0d stored), %0d dropped, %0d results, %0d full stalls.",
                 sb.writes, sb.stored, sb.ignored, sb.checked, full_stall_cycles);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/rls_pkg.sv
hw/rtl/rls_front.sv
hw/rtl/rls_cmd_fifo.sv
hw/rtl/rls_back.sv
hw/rtl/rotating_led_segment_driver.sv
verif/tb_top.sv
